### design/qoi_pkg.sv
// Shared types and constants for the queue with offset insert.
package qoi_pkg;

	// Default sizing
	localparam int DEPTH_DEF     = 16;
	localparam int ITEM_BITS_DEF = 16;

	// Fixed port widths
	localparam int ITEM_W = 16;
	localparam int PRI_W  = 5;
	localparam int OCC_W  = 5;

	// Operation codes
	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	// Per-cycle shift command broadcast to every cell
	typedef struct packed {
		logic enq;
		logic deq;
	} shift_ctrl_t;

endpackage

### design/queue_with_offset_insert.sv
// Top level of the queue with offset insert.
//
// A bounded queue of DEPTH tags held in a row of cells, head in cell 0. An
// enqueue (op 0) places the tag so that priority_req tags stay behind it,
// counted from the tail; priority 0 appends and any priority at or above the
// fill count puts the tag at the head. A full queue rejects the enqueue and
// flags it. A dequeue (op 1) returns the head tag with out_valid high, or 0 with
// out_valid low when empty. Every transaction yields exactly one result, with
// the occupancy after it. Every cell compares its index with the insert point
// and shifts in the same cycle, so a new transaction is taken every clock while
// results are drained; the command side stalls only while a result is held in
// the output register under res_stall. The result appears in the cycle after
// acceptance.
module queue_with_offset_insert
	import qoi_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int ITEM_BITS = ITEM_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic              op,
	input  logic [ITEM_W-1:0] item,
	input  logic [PRI_W-1:0]  priority_req,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [ITEM_W-1:0] out_item,
	output logic              out_valid,
	output logic              rejected,
	output logic [OCC_W-1:0]  occupancy
);

	localparam int POS_W = $clog2(DEPTH);

	shift_ctrl_t          ctrl;
	logic [POS_W-1:0]     pos;
	logic [ITEM_BITS-1:0] tag;
	logic [ITEM_BITS-1:0] slot [DEPTH];

	assign tag = ITEM_BITS'(item);

	// Control
	qoi_ctrl #(
		.DEPTH     (DEPTH),
		.ITEM_BITS (ITEM_BITS),
		.POS_W     (POS_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.op           (op),
		.priority_req (priority_req),
		.head_data    (slot[0]),
		.ctrl         (ctrl),
		.pos          (pos),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.out_item     (out_item),
		.out_valid    (out_valid),
		.rejected     (rejected),
		.occupancy    (occupancy)
	);

	// Row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ITEM_BITS-1:0] prev_d;
		logic [ITEM_BITS-1:0] next_d;

		if (i == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_mid
			assign prev_d = slot[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_inner
			assign next_d = slot[i+1];
		end

		qoi_cell #(
			.IDX       (i),
			.ITEM_BITS (ITEM_BITS),
			.POS_W     (POS_W)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.pos       (pos),
			.tag       (tag),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (slot[i])
		);
	end

	// Checks
	a_res_follows_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> res_valid)
		else $error("accepted transaction produced no result");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(out_valid && rejected))
		else $error("result both delivered and rejected");

	a_reject_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && rejected) |-> (occupancy == OCC_W'(DEPTH)))
		else $error("reject with queue not full");

	a_empty_item_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_valid) |-> (out_item == '0))
		else $error("non-zero item without delivery");

endmodule

### design/qoi_cell.sv
// One storage cell of the queue: holds a slot and shifts with its neighbours.
module qoi_cell
	import qoi_pkg::*;
#(
	parameter int IDX       = 0,
	parameter int ITEM_BITS = ITEM_BITS_DEF,
	parameter int POS_W     = 4
) (
	input  logic                 clk,
	input  shift_ctrl_t          ctrl,
	input  logic [POS_W-1:0]     pos,
	input  logic [ITEM_BITS-1:0] tag,
	input  logic [ITEM_BITS-1:0] prev_data,
	input  logic [ITEM_BITS-1:0] next_data,
	output logic [ITEM_BITS-1:0] data
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

	logic [ITEM_BITS-1:0] data_q;

	// Insert: cells ahead of the insert point hold, the point takes the tag,
	// cells behind it take their predecessor. Remove: every cell takes its successor.
	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (MY_POS == pos) begin
				data_q <= tag;
			end else if (MY_POS > pos) begin
				data_q <= prev_data;
			end
		end else if (ctrl.deq) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

### design/qoi_ctrl.sv
// Fill count, insert point decode and result register of the queue.
module qoi_ctrl
	import qoi_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int ITEM_BITS = ITEM_BITS_DEF,
	parameter int POS_W     = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic                 op,
	input  logic [PRI_W-1:0]     priority_req,
	input  logic [ITEM_BITS-1:0] head_data,
	output shift_ctrl_t          ctrl,
	output logic [POS_W-1:0]     pos,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [ITEM_W-1:0]    out_item,
	output logic                 out_valid,
	output logic                 rejected,
	output logic [OCC_W-1:0]     occupancy
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > PRI_W) ? CNT_W : PRI_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              accept;
	logic              full;
	logic              empty;
	logic              is_deq;
	logic [CMP_W-1:0]  pri_c;
	logic [CMP_W-1:0]  cnt_c;

	logic              res_valid_q;
	logic [ITEM_W-1:0] out_item_q;
	logic              out_valid_q;
	logic              rejected_q;
	logic [OCC_W-1:0]  occupancy_q;

	// Transaction handshake
	assign cmd_stall = res_valid_q & res_stall;
	assign accept    = cmd_valid & ~cmd_stall;
	assign is_deq    = (op_t'(op) == OP_DEQ);
	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);

	assign ctrl.enq = accept & ~is_deq & ~full;
	assign ctrl.deq = accept & is_deq & ~empty;

	// Insert point, an oversized priority clamps to the head
	assign pri_c = CMP_W'(priority_req);
	assign cnt_c = CMP_W'(count_q);
	always_comb begin
		if (pri_c >= cnt_c) begin
			pos = '0;
		end else begin
			pos = POS_W'(cnt_c - pri_c);
		end
	end

	// Next fill count
	always_comb begin
		count_d = count_q;
		if (ctrl.enq) begin
			count_d = count_q + 1'b1;
		end else if (ctrl.deq) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q  <= ctrl.deq ? ITEM_W'(head_data) : '0;
			out_valid_q <= ctrl.deq;
			rejected_q  <= ~is_deq & full;
			occupancy_q <= OCC_W'(count_d);
		end
	end

	assign res_valid = res_valid_q;
	assign out_item  = out_item_q;
	assign out_valid = out_valid_q;
	assign rejected  = rejected_q;
	assign occupancy = occupancy_q;

endmodule
